/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the fan speed filter.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/fanlag_pkg.sv */
// Package for the fan speed lag and slew filter: constants, register indexes,
// update kind codes and internal datapath widths. Depends on nothing.
package fanlag_pkg;

	localparam int DEFAULT_CHANNELS      = 8;
	localparam int DEFAULT_FRACTION_BITS = 12;

	// Bit-serial datapath widths.
	localparam int MUL_W   = 33;
	localparam int MUL_B_W = 17;
	localparam int DIV_W   = 32;
	localparam int DIV_D_W = 17;
	localparam int DT_W    = 13;
	localparam int STEP_W  = 17;
	localparam int LIM_W   = 19;
	localparam int CNT_W   = 6;

	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MUL_B_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);

	localparam logic [31:0]        RESET_GAP_MS    = 32'd5000;
	localparam logic [31:0]        HOLD_GAP_MS     = 32'd100;
	localparam logic [15:0]        MIN_STOP_RPM    = 16'd10;
	localparam logic [15:0]        DEFAULT_MAX_RPM = 16'd5000;
	localparam logic [DIV_D_W-1:0] MS_PER_S        = DIV_D_W'(1000);

	localparam logic [7:0]  RST_COUNT_MULT = 8'd1;
	localparam logic [9:0]  RST_STEPS      = 10'd0;
	localparam logic [15:0] RST_MAX_RPM    = 16'd5000;
	localparam logic [15:0] RST_TAU_MS     = 16'd1000;
	localparam logic [15:0] RST_SLEW       = 16'd1250;
	localparam logic [15:0] RST_STOP       = 16'd50;

	typedef logic [2:0] reg_index_t;

	localparam reg_index_t REG_COUNT_MULT = 3'd0;
	localparam reg_index_t REG_STEPS      = 3'd1;
	localparam reg_index_t REG_MAX_RPM    = 3'd2;
	localparam reg_index_t REG_TAU_MS     = 3'd3;
	localparam reg_index_t REG_SLEW       = 3'd4;
	localparam reg_index_t REG_STOP       = 3'd5;

	typedef enum logic [2:0] {
		KIND_STOP  = 3'd0,
		KIND_RESET = 3'd1,
		KIND_HOLD  = 3'd2,
		KIND_SAME  = 3'd3,
		KIND_STEP  = 3'd4
	} kind_t;

endpackage

/* rtl/core/fan_rpm_lag_slew_filter_top.sv */
// Fan speed filter top level: RPM conversion, per-channel lag step and slew limit.
// Depends on fanlag_pkg and assert_macros.svh.
//
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
// in        in         in_valid/in_stall    channel, raw_count, now_ms
// out       out        out_valid/out_stall  filtered_rpm, raw_rpm, update_kind
//
// One request is worked on at a time; the next is taken once the result sits in the
// output register. A request runs the shift-add multiplier and, in steps mode, then the
// restoring divider; a lag step adds the divider, the multiplier twice and the divider
// again. Both work one bit a cycle, over 17 multiplier bits and 32 quotient bits.
// Reset clears configuration to its defaults and all channel state at once.
// A stalled output holds its result; the block then waits before taking the next one.
`include "assert_macros.svh"

module fan_rpm_lag_slew_filter_top #(
	parameter int CHANNELS      = fanlag_pkg::DEFAULT_CHANNELS,
	parameter int FRACTION_BITS = fanlag_pkg::DEFAULT_FRACTION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  channel,
	input  logic [15:0] raw_count,
	input  logic [31:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] filtered_rpm,
	output logic [15:0] raw_rpm,
	output logic [2:0]  update_kind
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MUL_W   = fanlag_pkg::MUL_W;
	localparam int MUL_B_W = fanlag_pkg::MUL_B_W;
	localparam int DIV_W   = fanlag_pkg::DIV_W;
	localparam int DIV_D_W = fanlag_pkg::DIV_D_W;
	localparam int DT_W    = fanlag_pkg::DT_W;
	localparam int STEP_W  = fanlag_pkg::STEP_W;
	localparam int LIM_W   = fanlag_pkg::LIM_W;
	localparam int CNT_W   = fanlag_pkg::CNT_W;
	localparam logic [MUL_W-1:0] ROUND_MASK = MUL_W'((64'd1 << FRACTION_BITS) - 64'd1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV_MUL,
		ST_CONV_DIV,
		ST_DECIDE,
		ST_ALPHA_DIV,
		ST_STEP_MUL,
		ST_SLEW_MUL,
		ST_SLEW_DIV,
		ST_APPLY,
		ST_DONE
	} state_t;

	// Configuration registers.
	logic [7:0]  mult_q;
	logic [9:0]  steps_q;
	logic [15:0] max_rpm_q;
	logic [15:0] tau_q;
	logic [15:0] slew_q;
	logic [15:0] stop_q;

	// Per-channel state.
	logic [15:0] filt_mem_q [CHANNELS];
	logic [31:0] time_mem_q [CHANNELS];
	logic        seen_q     [CHANNELS];

	state_t                   state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [2:0]               ch_q;
	logic [31:0]              now_q;
	logic [15:0]              raw_q;
	logic [15:0]              filt_q;
	logic                     dneg_q;
	logic [15:0]              dmag_q;
	logic [DT_W-1:0]          dt_q;
	logic [MUL_W-1:0]         prod_q;
	logic [STEP_W-1:0]        step_q;
	logic [LIM_W-1:0]         lim_q;
	logic [15:0]              res_filt_q;
	fanlag_pkg::kind_t        kind_q;
	logic [MUL_W-1:0]         mul_acc_q;
	logic [MUL_W-1:0]         mul_a_q;
	logic [MUL_B_W-1:0]       mul_b_q;
	logic [DIV_W-1:0]         div_quo_q;
	logic [DIV_D_W-1:0]       div_rem_q;
	logic [DIV_D_W-1:0]       div_den_q;
	logic                     out_valid_q;
	logic [15:0]              out_filt_q;
	logic [15:0]              out_raw_q;
	fanlag_pkg::kind_t        out_kind_q;

	logic [15:0]        top_rpm;
	logic [15:0]        thr;
	logic [MUL_W-1:0]   acc_nx;
	logic [DIV_D_W:0]   rem_sh;
	logic               rem_ge;
	logic [DIV_D_W:0]   rem_nx;
	logic [DIV_W-1:0]   quo_nx;
	logic [MUL_W-1:0]   conv_val;
	logic [15:0]        raw_nx;
	logic [CH_W-1:0]    ch_idx;
	logic               ch_ok;
	logic [15:0]        cur_filt;
	logic [31:0]        dt_full;
	logic [MUL_W-1:0]   prod_rnd;
	logic [STEP_W-1:0]  step_raw;
	logic [STEP_W-1:0]  step_nx;
	logic [LIM_W-1:0]   lim_eff;
	logic [STEP_W-1:0]  smag;
	logic [15:0]        new_filt;
	logic               iter_last;
	logic               iter_busy;
	logic               out_load;
	logic               stop_out;

	assign cfg_ready    = 1'b1;
	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign filtered_rpm = out_filt_q;
	assign raw_rpm      = out_raw_q;
	assign update_kind  = out_kind_q;

	always_comb begin
		top_rpm = (max_rpm_q == 16'd0) ? fanlag_pkg::DEFAULT_MAX_RPM : max_rpm_q;
		thr     = (stop_q < fanlag_pkg::MIN_STOP_RPM) ? fanlag_pkg::MIN_STOP_RPM : stop_q;

		// One shift-add step of the multiplier and one restoring step of the divider.
		acc_nx = mul_acc_q + (mul_b_q[0] ? mul_a_q : '0);
		rem_sh = {div_rem_q, div_quo_q[DIV_W-1]};
		rem_ge = (rem_sh >= {1'b0, div_den_q});
		rem_nx = rem_ge ? (rem_sh - {1'b0, div_den_q}) : rem_sh;
		quo_nx = {div_quo_q[DIV_W-2:0], rem_ge};

		conv_val = (state_q == ST_CONV_DIV) ? MUL_W'(quo_nx) : acc_nx;
		raw_nx   = (conv_val > MUL_W'(top_rpm)) ? top_rpm : conv_val[15:0];

		ch_idx   = CH_W'(ch_q);
		ch_ok    = (32'(ch_q) < 32'(CHANNELS));
		cur_filt = filt_mem_q[ch_idx];
		dt_full  = now_q - time_mem_q[ch_idx];

		// A negative step rounds towards minus infinity, so its magnitude rounds up.
		prod_rnd = dneg_q ? (prod_q + ROUND_MASK) : prod_q;
		step_raw = STEP_W'(prod_rnd >> FRACTION_BITS);
		step_nx  = (step_raw == '0) ? STEP_W'(1) : step_raw;

		lim_eff  = (lim_q == '0) ? LIM_W'(1) : lim_q;
		smag     = (LIM_W'(step_q) > lim_eff) ? STEP_W'(lim_eff) : step_q;
		new_filt = dneg_q ? (filt_q - smag[15:0]) : (filt_q + smag[15:0]);

		iter_last = (cnt_q == CNT_W'(1));
		iter_busy = (state_q == ST_CONV_MUL) || (state_q == ST_CONV_DIV)
			|| (state_q == ST_ALPHA_DIV) || (state_q == ST_STEP_MUL)
			|| (state_q == ST_SLEW_MUL) || (state_q == ST_SLEW_DIV);
		out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		stop_out  = out_valid && (update_kind == fanlag_pkg::KIND_STOP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q    <= fanlag_pkg::RST_COUNT_MULT;
			steps_q   <= fanlag_pkg::RST_STEPS;
			max_rpm_q <= fanlag_pkg::RST_MAX_RPM;
			tau_q     <= fanlag_pkg::RST_TAU_MS;
			slew_q    <= fanlag_pkg::RST_SLEW;
			stop_q    <= fanlag_pkg::RST_STOP;
		end else if (cfg_valid) begin
			case (cfg_index)
				fanlag_pkg::REG_COUNT_MULT: mult_q    <= cfg_data[7:0];
				fanlag_pkg::REG_STEPS:      steps_q   <= cfg_data[9:0];
				fanlag_pkg::REG_MAX_RPM:    max_rpm_q <= cfg_data;
				fanlag_pkg::REG_TAU_MS:     tau_q     <= cfg_data;
				fanlag_pkg::REG_SLEW:       slew_q    <= cfg_data;
				fanlag_pkg::REG_STOP:       stop_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				filt_mem_q[i] <= '0;
				time_mem_q[i] <= '0;
				seen_q[i]     <= 1'b0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						ch_q      <= channel;
						now_q     <= now_ms;
						mul_acc_q <= '0;
						cnt_q     <= fanlag_pkg::MUL_STEPS;
						if (steps_q != 10'd0) begin
							mul_a_q <= MUL_W'(top_rpm);
							mul_b_q <= MUL_B_W'(raw_count);
						end else begin
							mul_a_q <= MUL_W'(raw_count);
							mul_b_q <= MUL_B_W'(mult_q);
						end
						state_q <= ST_CONV_MUL;
					end
				end
				ST_CONV_MUL: begin
					mul_acc_q <= acc_nx;
					mul_a_q   <= mul_a_q << 1;
					mul_b_q   <= mul_b_q >> 1;
					if (!iter_last) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (steps_q != 10'd0) begin
						div_quo_q <= acc_nx[DIV_W-1:0];
						div_rem_q <= '0;
						div_den_q <= DIV_D_W'(steps_q);
						cnt_q     <= fanlag_pkg::DIV_STEPS;
						state_q   <= ST_CONV_DIV;
					end else begin
						cnt_q   <= '0;
						raw_q   <= raw_nx;
						state_q <= ST_DECIDE;
					end
				end
				ST_CONV_DIV: begin
					div_quo_q <= quo_nx;
					div_rem_q <= rem_nx[DIV_D_W-1:0];
					cnt_q     <= cnt_q - CNT_W'(1);
					if (iter_last) begin
						raw_q   <= raw_nx;
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_DONE;
					if (!ch_ok) begin
						res_filt_q <= '0;
						kind_q     <= fanlag_pkg::KIND_STOP;
					end else if (raw_q < thr) begin
						filt_mem_q[ch_idx] <= '0;
						time_mem_q[ch_idx] <= now_q;
						seen_q[ch_idx]     <= 1'b1;
						res_filt_q         <= '0;
						kind_q             <= fanlag_pkg::KIND_STOP;
					end else if (!seen_q[ch_idx] || (dt_full > fanlag_pkg::RESET_GAP_MS)) begin
						filt_mem_q[ch_idx] <= raw_q;
						time_mem_q[ch_idx] <= now_q;
						seen_q[ch_idx]     <= 1'b1;
						res_filt_q         <= raw_q;
						kind_q             <= fanlag_pkg::KIND_RESET;
					end else if (dt_full < fanlag_pkg::HOLD_GAP_MS) begin
						res_filt_q <= cur_filt;
						kind_q     <= fanlag_pkg::KIND_HOLD;
					end else if (raw_q == cur_filt) begin
						time_mem_q[ch_idx] <= now_q;
						res_filt_q         <= cur_filt;
						kind_q             <= fanlag_pkg::KIND_SAME;
					end else begin
						time_mem_q[ch_idx] <= now_q;
						filt_q    <= cur_filt;
						dneg_q    <= (raw_q < cur_filt);
						dmag_q    <= (raw_q < cur_filt) ? (cur_filt - raw_q) : (raw_q - cur_filt);
						dt_q      <= dt_full[DT_W-1:0];
						div_quo_q <= DIV_W'(dt_full[DT_W-1:0]) << FRACTION_BITS;
						div_rem_q <= '0;
						div_den_q <= DIV_D_W'(tau_q) + DIV_D_W'(dt_full[DT_W-1:0]);
						cnt_q     <= fanlag_pkg::DIV_STEPS;
						kind_q    <= fanlag_pkg::KIND_STEP;
						state_q   <= ST_ALPHA_DIV;
					end
				end
				ST_ALPHA_DIV: begin
					div_quo_q <= quo_nx;
					div_rem_q <= rem_nx[DIV_D_W-1:0];
					if (iter_last) begin
						mul_acc_q <= '0;
						mul_a_q   <= MUL_W'(dmag_q);
						mul_b_q   <= quo_nx[MUL_B_W-1:0];
						cnt_q     <= fanlag_pkg::MUL_STEPS;
						state_q   <= ST_STEP_MUL;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_STEP_MUL: begin
					if (iter_last) begin
						prod_q    <= acc_nx;
						mul_acc_q <= '0;
						mul_a_q   <= MUL_W'(slew_q);
						mul_b_q   <= MUL_B_W'(dt_q);
						cnt_q     <= fanlag_pkg::MUL_STEPS;
						state_q   <= ST_SLEW_MUL;
					end else begin
						mul_acc_q <= acc_nx;
						mul_a_q   <= mul_a_q << 1;
						mul_b_q   <= mul_b_q >> 1;
						cnt_q     <= cnt_q - CNT_W'(1);
					end
				end
				ST_SLEW_MUL: begin
					step_q    <= step_nx;
					mul_acc_q <= acc_nx;
					mul_a_q   <= mul_a_q << 1;
					mul_b_q   <= mul_b_q >> 1;
					if (iter_last) begin
						div_quo_q <= acc_nx[DIV_W-1:0];
						div_rem_q <= '0;
						div_den_q <= fanlag_pkg::MS_PER_S;
						cnt_q     <= fanlag_pkg::DIV_STEPS;
						state_q   <= ST_SLEW_DIV;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_SLEW_DIV: begin
					div_quo_q <= quo_nx;
					div_rem_q <= rem_nx[DIV_D_W-1:0];
					cnt_q     <= cnt_q - CNT_W'(1);
					if (iter_last) begin
						lim_q   <= LIM_W'(quo_nx);
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					filt_mem_q[ch_idx] <= new_filt;
					res_filt_q         <= new_filt;
					state_q            <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_filt_q <= res_filt_q;
						out_raw_q  <= raw_q;
						out_kind_q <= kind_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, state_q != ST_IDLE)
	`ASSERT_IMPL(a_stop_zero, clk, arst_n, stop_out, filtered_rpm == 16'd0)
	`ASSERT_IMPL(a_cnt_iter, clk, arst_n, cnt_q != '0, iter_busy)

endmodule

/* sim/fanlag_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the fan speed lag and slew filter: watches the register, request and result
// channels, predicts each result per channel and compares it field by field.
// Depends on fanlag_pkg for register indexes, update kinds and fixed limits.
module fanlag_checker #(
	parameter int CHANNELS      = fanlag_pkg::DEFAULT_CHANNELS,
	parameter int FRACTION_BITS = fanlag_pkg::DEFAULT_FRACTION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  channel,
	input  logic [15:0] raw_count,
	input  logic [31:0] now_ms,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] filtered_rpm,
	input  logic [15:0] raw_rpm,
	input  logic [2:0]  update_kind,
	output int          mismatch_count,
	output int          pending,
	output int          result_count,
	output int          lag_step_count,
	output logic [4:0]  kinds_seen
);

	typedef struct packed {
		logic [2:0]        ch;
		logic [15:0]       filtered;
		logic [15:0]       raw;
		fanlag_pkg::kind_t kind;
	} speed_result_t;

	logic [7:0]  per_count_rpm;
	logic [9:0]  full_steps;
	logic [15:0] max_rpm;
	logic [15:0] tau_ms;
	logic [15:0] slew_rpm;
	logic [15:0] stop_rpm;

	logic [15:0] smoothed [CHANNELS];
	logic [31:0] last_ms [CHANNELS];
	logic        seen [CHANNELS];

	speed_result_t expected_speeds [$];
	int          mismatches;
	int          results;
	int          steps_taken;
	logic [4:0]  kinds;

	function automatic logic [15:0] rpm_of_count(input logic [15:0] count);
		logic [63:0] full;
		logic [63:0] rpm;
		full = (max_rpm == '0) ? 64'(fanlag_pkg::DEFAULT_MAX_RPM) : 64'(max_rpm);
		if (full_steps != '0)
			rpm = (full * 64'(count)) / 64'(full_steps);
		else
			rpm = 64'(count) * 64'(per_count_rpm);
		if (rpm > full)
			rpm = full;
		return rpm[15:0];
	endfunction

	function automatic longint lag_increment(input longint delta, input logic [31:0] dt);
		logic [63:0] weight;
		longint      inc;
		longint      limit;
		weight = ({32'd0, dt} << FRACTION_BITS) / ({48'd0, tau_ms} + {32'd0, dt});
		inc = (delta * longint'(weight)) >>> FRACTION_BITS;
		if (inc == 0)
			inc = (delta > 0) ? 64'sd1 : -64'sd1;
		limit = longint'(({48'd0, slew_rpm} * {32'd0, dt}) / 64'(fanlag_pkg::MS_PER_S));
		if (limit < 1)
			limit = 1;
		if (inc > limit)
			inc = limit;
		else if (inc < -limit)
			inc = -limit;
		return inc;
	endfunction

	function automatic speed_result_t predict_speed(input logic [2:0] ch,
			input logic [15:0] count, input logic [31:0] stamp);
		speed_result_t r;
		logic [15:0]   floor_rpm;
		logic [31:0]   dt;
		longint        delta;
		r.ch = ch;
		r.raw = rpm_of_count(count);
		floor_rpm = (stop_rpm < fanlag_pkg::MIN_STOP_RPM) ? fanlag_pkg::MIN_STOP_RPM
			: stop_rpm;
		if (int'(ch) >= CHANNELS) begin
			r.filtered = '0;
			r.kind = fanlag_pkg::KIND_STOP;
			return r;
		end
		dt = stamp - last_ms[ch];
		if (r.raw < floor_rpm) begin
			smoothed[ch] = '0;
			last_ms[ch] = stamp;
			seen[ch] = 1'b1;
			r.kind = fanlag_pkg::KIND_STOP;
		end else if (!seen[ch] || dt > fanlag_pkg::RESET_GAP_MS) begin
			smoothed[ch] = r.raw;
			last_ms[ch] = stamp;
			seen[ch] = 1'b1;
			r.kind = fanlag_pkg::KIND_RESET;
		end else if (dt < fanlag_pkg::HOLD_GAP_MS) begin
			r.kind = fanlag_pkg::KIND_HOLD;
		end else begin
			delta = longint'(r.raw) - longint'(smoothed[ch]);
			if (delta == 0) begin
				r.kind = fanlag_pkg::KIND_SAME;
			end else begin
				smoothed[ch] = 16'(longint'(smoothed[ch]) + lag_increment(delta, dt));
				r.kind = fanlag_pkg::KIND_STEP;
			end
			last_ms[ch] = stamp;
		end
		r.filtered = smoothed[ch];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		speed_result_t want;
		if (!arst_n) begin
			per_count_rpm = fanlag_pkg::RST_COUNT_MULT;
			full_steps = fanlag_pkg::RST_STEPS;
			max_rpm = fanlag_pkg::RST_MAX_RPM;
			tau_ms = fanlag_pkg::RST_TAU_MS;
			slew_rpm = fanlag_pkg::RST_SLEW;
			stop_rpm = fanlag_pkg::RST_STOP;
			for (int i = 0; i < CHANNELS; i++) begin
				smoothed[i] = '0;
				last_ms[i] = '0;
				seen[i] = 1'b0;
			end
			expected_speeds.delete();
			mismatches = 0;
			results = 0;
			steps_taken = 0;
			kinds = '0;
		end else begin
			if (out_valid && !out_stall) begin
				results++;
				if (expected_speeds.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("checker: result with no request waiting: %0d %0d %0d",
							filtered_rpm, raw_rpm, update_kind);
				end else begin
					want = expected_speeds.pop_front();
					if (filtered_rpm !== want.filtered || raw_rpm !== want.raw
							|| update_kind !== want.kind) begin
						mismatches++;
						if (mismatches <= 10)
							$display("checker: ch %0d want %0d %0d %0d, got %0d %0d %0d",
								want.ch, want.filtered, want.raw, want.kind,
								filtered_rpm, raw_rpm, update_kind);
					end
					kinds[want.kind] = 1'b1;
					if (want.kind == fanlag_pkg::KIND_STEP)
						steps_taken++;
				end
			end
			if (in_valid && !in_stall)
				expected_speeds.push_back(predict_speed(channel, raw_count, now_ms));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					fanlag_pkg::REG_COUNT_MULT: per_count_rpm = cfg_data[7:0];
					fanlag_pkg::REG_STEPS:      full_steps = cfg_data[9:0];
					fanlag_pkg::REG_MAX_RPM:    max_rpm = cfg_data;
					fanlag_pkg::REG_TAU_MS:     tau_ms = cfg_data;
					fanlag_pkg::REG_SLEW:       slew_rpm = cfg_data;
					fanlag_pkg::REG_STOP:       stop_rpm = cfg_data;
					default: ;
				endcase
			end
		end
		mismatch_count <= mismatches;
		pending <= expected_speeds.size();
		result_count <= results;
		lag_step_count <= steps_taken;
		kinds_seen <= kinds;
	end

endmodule

/* sim/tb_fan_rpm_lag_slew_filter_top.sv */
`timescale 1ns / 1ps
// Testbench top for the fan speed lag and slew filter: clock, reset, register settings,
// tachometer requests and result stalls, with the verdict taken from fanlag_checker.
// Depends on fanlag_pkg, fanlag_checker and fan_rpm_lag_slew_filter_top.
module tb_fan_rpm_lag_slew_filter_top;

	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int DRAIN_CYCLES    = 200;
	localparam int LONG_HOLD       = 300;

	typedef struct packed {
		logic [7:0]  mult;
		logic [9:0]  steps;
		logic [15:0] max_rpm;
		logic [15:0] tau_ms;
		logic [15:0] slew;
		logic [15:0] stop;
	} filter_settings_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  channel = '0;
	logic [15:0] raw_count = '0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] filtered_rpm;
	logic [15:0] raw_rpm;
	logic [2:0]  update_kind;

	int          mismatch_count;
	int          pending;
	int          result_count;
	int          lag_step_count;
	logic [4:0]  kinds_seen;

	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          rx_hold_req = 1'b0;
	int          count_span = 65535;
	int          settings_used = 0;
	int          sent = 0;

	fan_rpm_lag_slew_filter_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.channel      (channel),
		.raw_count    (raw_count),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.filtered_rpm (filtered_rpm),
		.raw_rpm      (raw_rpm),
		.update_kind  (update_kind)
	);

	fanlag_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.raw_count      (raw_count),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered_rpm   (filtered_rpm),
		.raw_rpm        (raw_rpm),
		.update_kind    (update_kind),
		.mismatch_count (mismatch_count),
		.pending        (pending),
		.result_count   (result_count),
		.lag_step_count (lag_step_count),
		.kinds_seen     (kinds_seen)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic filter_settings_t make_settings(input logic [7:0] mult,
			input logic [9:0] steps, input logic [15:0] max_rpm, input logic [15:0] tau_ms,
			input logic [15:0] slew, input logic [15:0] stop);
		filter_settings_t s;
		s.mult = mult;
		s.steps = steps;
		s.max_rpm = max_rpm;
		s.tau_ms = tau_ms;
		s.slew = slew;
		s.stop = stop;
		return s;
	endfunction

	task automatic write_reg(input fanlag_pkg::reg_index_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_settings(input filter_settings_t s);
		int full;
		write_reg(fanlag_pkg::REG_COUNT_MULT, 16'(s.mult));
		write_reg(fanlag_pkg::REG_STEPS, 16'(s.steps));
		write_reg(fanlag_pkg::REG_MAX_RPM, s.max_rpm);
		write_reg(fanlag_pkg::REG_TAU_MS, s.tau_ms);
		write_reg(fanlag_pkg::REG_SLEW, s.slew);
		write_reg(fanlag_pkg::REG_STOP, s.stop);
		cfg_valid <= 1'b0;
		full = (s.max_rpm == '0) ? int'(fanlag_pkg::DEFAULT_MAX_RPM) : int'(s.max_rpm);
		if (s.steps != '0)
			count_span = int'(s.steps);
		else if (s.mult == '0)
			count_span = 65535;
		else
			count_span = full / int'(s.mult);
		if (count_span < 1)
			count_span = 1;
		settings_used++;
	endtask

	task automatic send_request(input logic [2:0] ch, input logic [15:0] count,
			input logic [31:0] stamp);
		int unsigned gap;
		gap = tx_calm ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		channel <= ch;
		raw_count <= count;
		now_ms <= stamp;
		do @(posedge clk); while (in_stall);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin : receiver
		int unsigned hold;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold_req) begin
				hold = LONG_HOLD;
				rx_hold_req = 1'b0;
			end else begin
				hold = rx_calm ? 0 : $urandom_range(0, 11);
			end
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		filter_settings_t s;
		logic [31:0]      stamp [8];
		int               level [8];
		logic [2:0]       ch;
		logic [31:0]      dt;
		logic [15:0]      count;
		logic [15:0]      max_pick;
		logic [15:0]      tau_pick;
		logic [15:0]      slew_pick;
		int               pick;
		int               jitter;
		int               next_count;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Reset settings: stop, first sample, hold, unchanged, steps both ways, clamp,
		// stale gap, time wrap, and gaps of exactly 100 and 5000 ms.
		send_request(3'd0, 16'd0, 32'd100);
		send_request(3'd1, 16'd3000, 32'd1000);
		send_request(3'd1, 16'd3000, 32'd1050);
		send_request(3'd1, 16'd3000, 32'd1200);
		send_request(3'd1, 16'd4500, 32'd1400);
		send_request(3'd1, 16'd500, 32'd1600);
		send_request(3'd1, 16'hFFFF, 32'd1800);
		send_request(3'd1, 16'd2000, 32'd7000);
		send_request(3'd2, 16'd1000, 32'hFFFF_FF80);
		send_request(3'd2, 16'd1500, 32'h0000_0040);
		send_request(3'd3, 16'd1000, 32'd10000);
		send_request(3'd3, 16'd2000, 32'd10100);
		send_request(3'd3, 16'd3000, 32'd15100);
		send_request(3'd3, 16'd3000, 32'd20101);
		send_request(3'd4, 16'd49, 32'd300);
		send_request(3'd4, 16'd50, 32'd400);
		send_request(3'd7, 16'hFFFF, 32'hFFFF_FFFF);
		settle();

		apply_settings(make_settings(8'd255, 10'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		send_request(3'd5, 16'd5, 32'd0);
		send_request(3'd5, 16'hFFFF, 32'd200);
		send_request(3'd5, 16'd0, 32'd300);
		settle();

		apply_settings(make_settings(8'd0, 10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_request(3'd6, 16'd1023, 32'd1000);
		send_request(3'd6, 16'd1022, 32'd1100);
		send_request(3'd6, 16'hFFFF, 32'd1200);
		settle();

		apply_settings(make_settings(8'd0, 10'd0, 16'd1, 16'd0, 16'd0, 16'd9));
		send_request(3'd0, 16'hFFFF, 32'd5000);
		settle();

		for (int i = 0; i < 8; i++) begin
			stamp[i] = $urandom();
			level[i] = 0;
		end
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: s = make_settings(8'd255, 10'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
				1: s = make_settings(8'd0, 10'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
				default: begin
					case ($urandom_range(0, 5))
						0: max_pick = 16'd0;
						1: max_pick = 16'hFFFF;
						2: max_pick = 16'd1;
						default: max_pick = 16'($urandom_range(1000, 20000));
					endcase
					tau_pick = ($urandom_range(0, 5) == 0) ? 16'hFFFF
						: 16'($urandom_range(0, 4000));
					slew_pick = ($urandom_range(0, 4) == 0) ? 16'd0
						: 16'($urandom_range(1, 20000));
					s = make_settings(8'($urandom_range(0, 255)),
						($urandom_range(0, 1) != 0) ? 10'($urandom_range(1, 1023)) : 10'd0,
						max_pick, tau_pick, slew_pick, 16'($urandom_range(0, 400)));
				end
			endcase
			apply_settings(s);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 8; i++)
				level[i] = $urandom_range(0, count_span);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 3 && n == 20)
					rx_hold_req = 1'b1;
				ch = 3'($urandom_range(0, 7));
				pick = $urandom_range(0, 99);
				if (pick < 8)
					dt = $urandom_range(0, 99);
				else if (pick < 13)
					dt = $urandom_range(5001, 60000);
				else if (pick < 15)
					dt = $urandom();
				else if (pick == 15)
					dt = fanlag_pkg::HOLD_GAP_MS;
				else if (pick == 16)
					dt = fanlag_pkg::RESET_GAP_MS;
				else
					dt = $urandom_range(100, 2500);
				stamp[ch] = stamp[ch] + dt;

				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					count = '0;
				end else if (pick < 12) begin
					count = 16'($urandom());
				end else if (pick < 22) begin
					level[ch] = $urandom_range(0, count_span);
					count = 16'(level[ch]);
				end else begin
					jitter = int'($urandom_range(0, count_span / 8 + 1));
					next_count = ($urandom_range(0, 1) != 0) ? level[ch] + jitter
						: level[ch] - jitter;
					if (next_count < 0)
						next_count = 0;
					else if (next_count > 65535)
						next_count = 65535;
					count = 16'(next_count);
				end
				send_request(ch, count, stamp[ch]);
				if ($urandom_range(0, 49) == 0)
					settle();
			end
			settle();
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d requests under %0d register settings, %0d results, %0d lag steps",
			sent, settings_used, result_count, lag_step_count);
		$display("summary: update kinds seen (step same hold reset stop) %b", kinds_seen);
		if (mismatch_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
